// File: hdl/tsh_pkg.sv
// Shared types and constants for the k-smallest max-heap selector.
// Used by tsh_out_reg and topk_smallest_max_heap; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tsh_pkg;

    localparam int HEAP_SIZE  = 16;
    localparam int DIST_BITS  = 32;
    localparam int INDEX_BITS = 24;

    localparam int ADDR_W  = (HEAP_SIZE > 1) ? $clog2(HEAP_SIZE) : 1;
    localparam int CNT_W   = $clog2(HEAP_SIZE + 1);
    localparam int ENTRY_W = DIST_BITS + INDEX_BITS;
    localparam int TDATA_W = ((ENTRY_W + 7) / 8) * 8;

    typedef struct packed {
        logic [INDEX_BITS-1:0] index;
        logic [DIST_BITS-1:0]  distance;
    } t_entry;

    typedef struct packed {
        logic   last;
        t_entry ent;
    } t_result;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP,
        ST_UP_CMP,
        ST_ROOT,
        ST_ROOT_CMP,
        ST_DN_RD,
        ST_DN_CMP,
        ST_DN_END,
        ST_DR_RD,
        ST_DR_OUT
    } t_state;

endpackage

`default_nettype wire

// File: hdl/tsh_ram.sv
// Generic RAM: one write port, two read ports, read data registered.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tsh_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [DATA_W-1:0]                         i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr0,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr1,
    output logic      [DATA_W-1:0]                         o_rdata0,
    output logic      [DATA_W-1:0]                         o_rdata1
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule

`default_nettype wire

// File: hdl/tsh_out_reg.sv
// Output register for drained results; frees the heap engine from the sink.
// Depends on tsh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsh_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire tsh_pkg::t_result i_res,
    output logic                  o_free,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output tsh_pkg::t_result      o_res
);

    logic             r_valid;
    tsh_pkg::t_result r_res;

    // slot can be loaded when empty or being emptied this cycle
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

// File: hdl/topk_smallest_max_heap.sv
// K-smallest selector over a (distance, index) stream, binary max-heap in one RAM.
// Each transaction is accepted in IDLE. An insert then climbs through UP and UP_CMP per
// level; a root replacement reads the root (ROOT, ROOT_CMP) and sifts down through DN_RD and
// DN_CMP per level, with DN_END writing back at a leaf; a dropped candidate ends after ROOT_CMP.
// Each drained result passes DR_RD and DR_OUT, which waits out any output stall, then its
// sift-down. Reset (sync, active low) empties the heap via the count; RAM not cleared.
`timescale 1ns / 1ps
`default_nettype none

module topk_smallest_max_heap (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // candidate stream
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [tsh_pkg::TDATA_W-1:0]  s_axis_tdata,  // cand_dist, cand_index
    input  wire logic                         s_axis_tlast,  // cand_last
    // drained results, largest distance first
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic      [tsh_pkg::TDATA_W-1:0]  m_axis_tdata,  // out_dist, out_index
    output logic                              m_axis_tlast   // out_last
);

    localparam int AW = tsh_pkg::ADDR_W;
    localparam int CW = tsh_pkg::CNT_W;
    localparam int KW = tsh_pkg::ADDR_W + 2;   // child index before range check

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    tsh_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;   // held entries
    logic [AW-1:0]   r_pos,   n_pos;     // current hole in the heap
    logic            r_last,  n_last;    // drain after this transaction
    tsh_pkg::t_entry r_x,     n_x;       // entry being placed

    // ------------------------------------------------------------------
    // Heap RAM ports
    // ------------------------------------------------------------------
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    tsh_pkg::t_entry              ram_wdata;
    logic [AW-1:0]                ram_raddr0, ram_raddr1;
    logic [tsh_pkg::ENTRY_W-1:0]  ram_rdata0, ram_rdata1;
    tsh_pkg::t_entry              rd0, rd1;

    assign rd0 = tsh_pkg::t_entry'(ram_rdata0);
    assign rd1 = tsh_pkg::t_entry'(ram_rdata1);

    tsh_ram #(
        .DATA_W (tsh_pkg::ENTRY_W),
        .DEPTH  (tsh_pkg::HEAP_SIZE)
    ) u_ram (
        .i_clk    (i_clk),
        .i_we     (ram_we),
        .i_waddr  (ram_waddr),
        .i_wdata  (ram_wdata),
        .i_raddr0 (ram_raddr0),
        .i_raddr1 (ram_raddr1),
        .o_rdata0 (ram_rdata0),
        .o_rdata1 (ram_rdata1)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic             out_push, out_free;
    tsh_pkg::t_result out_in, out_q;

    tsh_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_res   (out_in),
        .o_free  (out_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_q)
    );

    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[tsh_pkg::ENTRY_W-1:0] = out_q.ent;
        m_axis_tlast = out_q.last;
    end

    // ------------------------------------------------------------------
    // Shared decisions
    // ------------------------------------------------------------------
    logic            in_acc;
    tsh_pkg::t_entry in_ent;
    logic            not_full;
    logic [AW-1:0]   parent;
    logic [KW-1:0]   lkid, rkid, sel_kid, sel_kid_l;
    logic            pick_r, dn_stop, kid_has_kids, up_swap, root_repl;
    tsh_pkg::t_entry kid;
    logic [CW-1:0]   tail;

    assign s_axis_tready = (r_state == tsh_pkg::ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_ent        = tsh_pkg::t_entry'(s_axis_tdata[tsh_pkg::ENTRY_W-1:0]);
    assign not_full      = (r_count < CW'(tsh_pkg::HEAP_SIZE));

    assign parent    = AW'((r_pos - 1'b1) >> 1);
    assign lkid      = {1'b0, r_pos, 1'b1};
    assign rkid      = lkid + 1'b1;
    // right child only if in range and strictly larger; parent stays only if strictly larger
    assign pick_r    = (rkid < KW'(r_count)) && (rd1.distance > rd0.distance);
    assign kid       = pick_r ? rd1 : rd0;
    assign sel_kid   = pick_r ? rkid : lkid;
    assign sel_kid_l = {1'b0, sel_kid[AW-1:0], 1'b1};
    assign dn_stop   = (r_x.distance > kid.distance);
    assign kid_has_kids = (sel_kid_l < KW'(r_count));

    assign up_swap   = (r_x.distance > rd0.distance);
    assign root_repl = (rd0.distance > r_x.distance);
    assign tail      = r_count - 1'b1;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tsh_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = not_full ? tsh_pkg::ST_UP : tsh_pkg::ST_ROOT;
                end
            end
            tsh_pkg::ST_UP: begin
                if (r_pos == '0) begin
                    n_state = r_last ? tsh_pkg::ST_DR_RD : tsh_pkg::ST_IDLE;
                end else begin
                    n_state = tsh_pkg::ST_UP_CMP;
                end
            end
            tsh_pkg::ST_UP_CMP: begin
                if (up_swap) begin
                    n_state = tsh_pkg::ST_UP;
                end else begin
                    n_state = r_last ? tsh_pkg::ST_DR_RD : tsh_pkg::ST_IDLE;
                end
            end
            tsh_pkg::ST_ROOT: begin
                n_state = tsh_pkg::ST_ROOT_CMP;
            end
            tsh_pkg::ST_ROOT_CMP: begin
                if (root_repl) begin
                    n_state = (r_count > CW'(1)) ? tsh_pkg::ST_DN_RD : tsh_pkg::ST_DN_END;
                end else begin
                    n_state = r_last ? tsh_pkg::ST_DR_RD : tsh_pkg::ST_IDLE;
                end
            end
            tsh_pkg::ST_DN_RD: begin
                n_state = tsh_pkg::ST_DN_CMP;
            end
            tsh_pkg::ST_DN_CMP: begin
                if (dn_stop) begin
                    n_state = r_last ? tsh_pkg::ST_DR_RD : tsh_pkg::ST_IDLE;
                end else begin
                    n_state = kid_has_kids ? tsh_pkg::ST_DN_RD : tsh_pkg::ST_DN_END;
                end
            end
            tsh_pkg::ST_DN_END: begin
                n_state = r_last ? tsh_pkg::ST_DR_RD : tsh_pkg::ST_IDLE;
            end
            tsh_pkg::ST_DR_RD: begin
                n_state = tsh_pkg::ST_DR_OUT;
            end
            tsh_pkg::ST_DR_OUT: begin
                if (out_free) begin
                    if (tail == '0) begin
                        n_state = tsh_pkg::ST_IDLE;
                    end else if (tail > CW'(1)) begin
                        n_state = tsh_pkg::ST_DN_RD;
                    end else begin
                        n_state = tsh_pkg::ST_DN_END;
                    end
                end
            end
            default: n_state = tsh_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and RAM control
    // ------------------------------------------------------------------
    always_comb begin
        n_count    = r_count;
        n_pos      = r_pos;
        n_last     = r_last;
        n_x        = r_x;
        ram_we     = 1'b0;
        ram_waddr  = r_pos;
        ram_wdata  = r_x;
        ram_raddr0 = '0;
        ram_raddr1 = '0;
        out_push   = 1'b0;
        out_in     = '{last: (tail == '0), ent: rd0};
        unique case (r_state) inside
            tsh_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_x    = in_ent;
                    n_last = s_axis_tlast;
                    if (not_full) begin
                        // new entry starts in the first free slot
                        n_pos   = AW'(r_count);
                        n_count = r_count + 1'b1;
                    end
                end
            end
            tsh_pkg::ST_UP: begin
                ram_raddr0 = parent;
                ram_we     = (r_pos == '0);
            end
            tsh_pkg::ST_UP_CMP: begin
                ram_we = 1'b1;
                if (up_swap) begin
                    ram_wdata = rd0;     // parent moves down into the hole
                    n_pos     = parent;
                end
            end
            tsh_pkg::ST_ROOT: begin
                ram_raddr0 = '0;
            end
            tsh_pkg::ST_ROOT_CMP: begin
                n_pos = '0;
            end
            tsh_pkg::ST_DN_RD: begin
                ram_raddr0 = lkid[AW-1:0];
                ram_raddr1 = rkid[AW-1:0];
            end
            tsh_pkg::ST_DN_CMP: begin
                ram_we = 1'b1;
                if (!dn_stop) begin
                    ram_wdata = kid;     // larger child moves up into the hole
                    n_pos     = sel_kid[AW-1:0];
                end
            end
            tsh_pkg::ST_DN_END: begin
                ram_we = 1'b1;
            end
            tsh_pkg::ST_DR_RD, tsh_pkg::ST_DR_OUT: begin
                ram_raddr0 = '0;
                ram_raddr1 = tail[AW-1:0];
                if (r_state == tsh_pkg::ST_DR_OUT && out_free) begin
                    out_push = 1'b1;
                    n_count  = tail;
                    n_x      = rd1;     // tail entry refills the root
                    n_pos    = '0;
                    if (tail == '0) begin
                        n_last = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsh_pkg::ST_IDLE;
            r_count <= '0;
            r_pos   <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pos   <= n_pos;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
    end

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking bench for topk_smallest_max_heap: directed and random candidate streams.
// Holds its own max-heap predictor; needs only tsh_pkg and the selector RTL.
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_TAIL  = 60;

    localparam int HEAP_SIZE  = tsh_pkg::HEAP_SIZE;
    localparam int DIST_BITS  = tsh_pkg::DIST_BITS;
    localparam int INDEX_BITS = tsh_pkg::INDEX_BITS;
    localparam int ENTRY_W    = tsh_pkg::ENTRY_W;
    localparam int TDATA_W    = tsh_pkg::TDATA_W;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [TDATA_W-1:0]   s_axis_tdata = '0;   // cand_dist, cand_index
    logic                 s_axis_tlast = 1'b0; // cand_last
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   m_axis_tdata;        // out_dist, out_index
    logic                 m_axis_tlast;        // out_last

    topk_smallest_max_heap u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    // predicted heap contents and the drained entries still to arrive
    logic [DIST_BITS-1:0]  heap_d  [HEAP_SIZE];
    logic [INDEX_BITS-1:0] heap_ix [HEAP_SIZE];
    int                    held_cnt = 0;
    tsh_pkg::t_result      drained_q [$];

    int  err_cnt = 0;
    int  cycle_cnt = 0;
    bit  quiet = 1'b0;   // no idling on either side when set
    int  rdy_hold = 0;

    function automatic void heap_swap(int a, int b);
        logic [DIST_BITS-1:0]  td;
        logic [INDEX_BITS-1:0] ti;
        td = heap_d[a];
        ti = heap_ix[a];
        heap_d[a] = heap_d[b];
        heap_ix[a] = heap_ix[b];
        heap_d[b] = td;
        heap_ix[b] = ti;
    endfunction

    // climb only past a strictly smaller parent
    function automatic void heap_climb(int pos);
        int parent;
        while (pos > 0) begin
            parent = (pos - 1) / 2;
            if (!(heap_d[pos] > heap_d[parent]))
                break;
            heap_swap(pos, parent);
            pos = parent;
        end
    endfunction

    // right child only if strictly larger; stop only if the parent is strictly larger
    function automatic void heap_descend(int n);
        int pos;
        int kid;
        pos = 0;
        while (2 * pos + 1 < n) begin
            kid = 2 * pos + 1;
            if (kid + 1 < n && heap_d[kid + 1] > heap_d[kid])
                kid = kid + 1;
            if (heap_d[pos] > heap_d[kid])
                break;
            heap_swap(pos, kid);
            pos = kid;
        end
    endfunction

    function automatic void absorb_candidate(logic [DIST_BITS-1:0] d,
                                             logic [INDEX_BITS-1:0] ix, logic lst);
        tsh_pkg::t_result r;
        int               tail;
        if (held_cnt < HEAP_SIZE) begin
            heap_d[held_cnt] = d;
            heap_ix[held_cnt] = ix;
            held_cnt++;
            heap_climb(held_cnt - 1);
        end else if (heap_d[0] > d) begin
            heap_d[0] = d;
            heap_ix[0] = ix;
            heap_descend(held_cnt);
        end
        if (lst) begin
            while (held_cnt > 0) begin
                tail = held_cnt - 1;
                r.ent.distance = heap_d[0];
                r.ent.index = heap_ix[0];
                r.last = (tail == 0);
                drained_q.push_back(r);
                heap_d[0] = heap_d[tail];
                heap_ix[0] = heap_ix[tail];
                held_cnt = tail;
                heap_descend(held_cnt);
            end
        end
    endfunction

    // One candidate transaction; tvalid stays high on return unless a gap follows.
    task automatic send_cand(input logic [DIST_BITS-1:0] d, input logic [INDEX_BITS-1:0] ix,
                             input logic lst);
        tsh_pkg::t_entry e;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        e.distance = d;
        e.index = ix;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= TDATA_W'(e);
        s_axis_tlast <= lst;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        absorb_candidate(d, ix, lst);
    endtask

    // mixes full-range values with narrow ranges that force ties
    function automatic logic [DIST_BITS-1:0] pick_dist(int mode);
        case (mode)
            0: begin
                return DIST_BITS'($urandom_range(0, 7));
            end
            1: begin
                return {DIST_BITS{1'b1}} - DIST_BITS'($urandom_range(0, 7));
            end
            default: begin
                return DIST_BITS'($urandom());
            end
        endcase
    endfunction

    // Random queries of mixed length; most overfill the heap to exercise replacement.
    task automatic send_queries(input int n_items);
        int sent;
        int qlen;
        int mode;
        sent = 0;
        while (sent < n_items) begin
            qlen = ($urandom_range(0, 3) == 0) ? $urandom_range(1, HEAP_SIZE)
                                               : $urandom_range(HEAP_SIZE + 1, 40);
            mode = $urandom_range(0, 3);
            for (int i = 0; i < qlen; i++)
                send_cand(pick_dist(mode), INDEX_BITS'($urandom()), i == qlen - 1);
            sent += qlen;
        end
    endtask

    // Extremes, ties, fill, equal-to-root drop, replacement and a dropped last candidate.
    task automatic test_directed();
        logic [DIST_BITS-1:0] fill [16] = '{32'd5, 32'd5, 32'd9, 32'd1, 32'd9, 32'd3, 32'd3,
                                            32'd7, 32'd0, 32'hFFFF_FFFF, 32'd2, 32'd2,
                                            32'd8, 32'd8, 32'd4, 32'd6};
        // single candidate query at full scale
        send_cand({DIST_BITS{1'b1}}, {INDEX_BITS{1'b1}}, 1'b1);
        for (int i = 0; i < HEAP_SIZE; i++)
            send_cand(fill[i], (i == 0) ? '0 : INDEX_BITS'(i * 24'h11_1111), 1'b0);
        send_cand({DIST_BITS{1'b1}}, 24'hABCDEF, 1'b0);   // equal to root, dropped
        send_cand(32'd5, {INDEX_BITS{1'b1}}, 1'b0);       // replaces root
        send_cand(32'd0, 24'h00_0001, 1'b0);              // replaces root
        send_cand(32'd9, 24'h12_3456, 1'b1);              // equal to root, dropped, drain
    endtask

    task automatic test_random_idle();
        send_queries(230);
    endtask

    task automatic test_back_to_back();
        quiet = 1'b1;
        send_queries(70);
    endtask

    // output side: stalls tready in random bursts
    always @(posedge i_clk) begin
        if (rdy_hold != 0) begin
            rdy_hold <= rdy_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rdy_hold <= $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // result transactions against the oldest predicted entry
    always @(posedge i_clk) begin
        tsh_pkg::t_entry  got;
        tsh_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = tsh_pkg::t_entry'(m_axis_tdata[ENTRY_W-1:0]);
            if (drained_q.size() == 0) begin
                $error("unexpected result: dist %0h index %0h", got.distance, got.index);
                err_cnt++;
            end else begin
                want = drained_q.pop_front();
                if (got.distance !== want.ent.distance) begin
                    $error("out_dist: expected %0h, got %0h", want.ent.distance,
                           got.distance);
                    err_cnt++;
                end
                if (got.index !== want.ent.index) begin
                    $error("out_index: expected %0h, got %0h", want.ent.index, got.index);
                    err_cnt++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("out_last: expected %0b, got %0b", want.last, m_axis_tlast);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_idle();
        test_back_to_back();
        s_axis_tvalid <= 1'b0;
        while (drained_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (err_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
